@@ src/grid_maze_backtracker_defines.svh @@
// assertion macros for the maze carving block
// no dependencies; taken in by the top level with a plain include
`ifndef GRID_MAZE_BACKTRACKER_DEFINES_SVH
`define GRID_MAZE_BACKTRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define GMB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmb: same-cycle check failed");
// next-cycle implication
`define GMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmb: next-cycle check failed");
`else
`define GMB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define GMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/gmb_pkg.sv @@
// shared types, constants and helpers of the maze carving block
// no dependencies; imported by gmb_pick, grid_maze_backtracker and the testbench
package gmb_pkg;

    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 32;

    localparam int RND_W   = 15;   // random word
    localparam int COORD_W = 5;    // reported column and row
    localparam int DIR_W   = 2;

    // mode field of the input word
    localparam logic MODE_RESTART = 1'b0;
    localparam logic MODE_STEP    = 1'b1;

    // neighbour directions, also the order in which they are tested
    localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
    localparam logic [DIR_W-1:0] DIR_EAST  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

    typedef struct packed {
        logic             valid;   // at least one unvisited neighbour
        logic [DIR_W-1:0] dir;     // chosen neighbour
    } t_pick;

    // remainder by three: reciprocal multiply, then one subtract
    function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
        logic [31:0] prod;
        logic [15:0] quo;
        logic [16:0] quo3;
        logic [RND_W-1:0] rem;
        prod = 32'(v) * 32'd21846;
        quo  = prod[31:16];
        quo3 = {quo, 1'b0} + {1'b0, quo};
        rem  = v - quo3[RND_W-1:0];
        return rem[1:0];
    endfunction

endpackage

@@ src/gmb_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module gmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/gmb_pick.sv @@
// picks one unvisited neighbour from the free mask and the random word
// depends on gmb_pkg (t_pick, direction codes)
module gmb_pick
    import gmb_pkg::*;
(
    input  logic [3:0] i_free,     // per direction, north first
    input  logic [1:0] i_rnd_lo,   // low bits of the random word
    input  logic [1:0] i_mod3,     // random word modulo three
    output t_pick      o_pick
);

    logic [2:0] w_cnt;
    logic [1:0] w_idx;
    logic [2:0] w_seen;
    logic [DIR_W-1:0] w_dir;

    always_comb begin
        w_cnt = 3'(i_free[0]) + 3'(i_free[1]) + 3'(i_free[2]) + 3'(i_free[3]);
        unique case (w_cnt)
            3'd2:    w_idx = {1'b0, i_rnd_lo[0]};
            3'd3:    w_idx = i_mod3;
            3'd4:    w_idx = i_rnd_lo;
            default: w_idx = 2'd0;
        endcase
        // walk the free list in direction order to the chosen entry
        w_dir  = DIR_NORTH;
        w_seen = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (i_free[i]) begin
                if (w_seen == {1'b0, w_idx}) begin
                    w_dir = DIR_W'(i);
                end
                w_seen = w_seen + 3'd1;
            end
        end
    end

    assign o_pick.valid = (w_cnt != 3'd0);
    assign o_pick.dir   = w_dir;

endmodule

@@ src/grid_maze_backtracker.sv @@
// grid_maze_backtracker: depth-first maze carving over a cell grid
// visited map and path stack live in two gmb_ram instances; the top cell,
// depth and remaining count are registers. depends on gmb_pkg, gmb_ram, gmb_pick
//
// usage:
//   input channel s_axis: tuser = mode (0 restart, 1 carve one step),
//   tdata = random word. output channel m_axis: one word per input word,
//   tdata = column, row and direction, tuser = carved and finished flags.
//   a step passes from acceptance through a dispatch state, a read state
//   that reads the four neighbour visited bits one per cycle through the
//   visited ram's single read port, a decision state for the push or pop
//   and the map write, and an emit state that loads the output register.
//   a restart runs the sweep that clears the map one entry per cycle
//   before its result; steps on a finished maze skip the reads and go
//   from dispatch straight to emit. the next word is accepted in the
//   cycle after a result is loaded, not while the last one is in flight.
//   after reset the same clearing sweep runs and s_axis_tready stays
//   low until it ends; no output word is produced.
//   if the receiver stalls, one further result waits inside the block
//   until the output register frees; no word is lost.
module grid_maze_backtracker
    import gmb_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [14:0] random_value, [15] zero fill
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] cell_x, [9:5] cell_y,
                                        // [11:10] direction, [15:12] zero
    output logic [1:0]  m_axis_tuser    // [0] carved, [1] finished
);

`include "grid_maze_backtracker_defines.svh"

    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);
    localparam int VAW    = XW + YW;             // visited map address {x, y}
    localparam int VDEPTH = 1 << VAW;
    localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int SAW    = $clog2(CELLS);       // stack address, remaining count
    localparam int DW     = $clog2(CELLS + 1);   // stack depth

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    // control
    logic [2:0]     r_state, n_state;
    logic [2:0]     r_phase, n_phase;
    logic [VAW-1:0] r_clr, n_clr;
    logic           r_emit, n_emit;       // restart result owed after the sweep
    logic [DW-1:0]  r_depth, n_depth;
    logic [SAW-1:0] r_remain, n_remain;
    logic [XW-1:0]  r_top_x, n_top_x;
    logic [YW-1:0]  r_top_y, n_top_y;
    logic           r_out_valid, n_out_valid;

    // item and working payload
    logic             r_mode, n_mode;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [1:0]       r_mod3, n_mod3;
    logic [3:0]       r_vis, n_vis;

    // pending result and output register
    logic [COORD_W-1:0] r_res_x, n_res_x;
    logic [COORD_W-1:0] r_res_y, n_res_y;
    logic [DIR_W-1:0]   r_res_dir, n_res_dir;
    logic               r_res_carved, n_res_carved;
    logic               r_res_fin, n_res_fin;
    logic [15:0]        r_out_data, n_out_data;
    logic [1:0]         r_out_user, n_out_user;

    // memory ports
    logic           w_vis_we;
    logic [VAW-1:0] w_vis_waddr;
    logic           w_vis_wdata;
    logic [VAW-1:0] w_vis_raddr;
    logic           w_vis_rdata;
    logic           w_stk_we;
    logic [SAW-1:0] w_stk_waddr;
    logic [VAW-1:0] w_stk_wdata;
    logic [SAW-1:0] w_stk_raddr;
    logic [VAW-1:0] w_stk_rdata;
    logic [DW-1:0]  w_depth_m2;

    logic [VAW-1:0] w_nb [4];
    logic [3:0]     w_ingrid;
    logic [VAW-1:0] w_next;
    logic           w_slot;
    logic           w_accept;
    t_pick          w_pick;
    logic           w_dec_carve;
    logic           w_dec_pop;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_slot   = !r_out_valid || m_axis_tready;

    // neighbour addresses of the top cell, in test order
    assign w_nb[DIR_NORTH] = {r_top_x, r_top_y - YW'(1)};
    assign w_nb[DIR_SOUTH] = {r_top_x, r_top_y + YW'(1)};
    assign w_nb[DIR_EAST]  = {r_top_x + XW'(1), r_top_y};
    assign w_nb[DIR_WEST]  = {r_top_x - XW'(1), r_top_y};

    assign w_ingrid[DIR_NORTH] = (r_top_y != '0);
    assign w_ingrid[DIR_SOUTH] = (r_top_y != YW'(GRID_HEIGHT - 1));
    assign w_ingrid[DIR_EAST]  = (r_top_x != XW'(GRID_WIDTH - 1));
    assign w_ingrid[DIR_WEST]  = (r_top_x != '0);

    assign w_next = w_nb[w_pick.dir];

    gmb_pick u_pick (
        .i_free   (~r_vis & w_ingrid),
        .i_rnd_lo (r_rnd[1:0]),
        .i_mod3   (r_mod3),
        .o_pick   (w_pick)
    );

    // the entry below the top stays stable for the whole step, so the
    // stack ram keeps reading it and a pop takes it from the read data
    assign w_depth_m2  = r_depth - DW'(2);
    assign w_stk_raddr = w_depth_m2[SAW-1:0];
    assign w_vis_raddr = w_nb[r_phase[1:0]];

    // memory writes: clearing sweep, or the carve in the decision cycle
    always_comb begin
        w_vis_we    = 1'b0;
        w_vis_waddr = r_clr;
        w_vis_wdata = (r_clr == '0);
        w_stk_we    = 1'b0;
        w_stk_waddr = '0;
        w_stk_wdata = '0;
        if (r_state == S_CLR) begin
            w_vis_we = 1'b1;
            w_stk_we = (r_clr == '0);   // stack base holds cell zero
        end else if (r_state == S_DEC && w_pick.valid) begin
            w_vis_we    = 1'b1;
            w_vis_waddr = w_next;
            w_vis_wdata = 1'b1;
            w_stk_we    = (r_depth < DW'(CELLS));
            w_stk_waddr = r_depth[SAW-1:0];
            w_stk_wdata = w_next;
        end
    end

    gmb_ram #(
        .WIDTH (1),
        .DEPTH (VDEPTH)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_raddr (w_vis_raddr),
        .o_rdata (w_vis_rdata)
    );

    gmb_ram #(
        .WIDTH (VAW),
        .DEPTH (CELLS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_clr        = r_clr;
        n_emit       = r_emit;
        n_depth      = r_depth;
        n_remain     = r_remain;
        n_top_x      = r_top_x;
        n_top_y      = r_top_y;
        n_mode       = r_mode;
        n_rnd        = r_rnd;
        n_mod3       = r_mod3;
        n_vis        = r_vis;
        n_res_x      = r_res_x;
        n_res_y      = r_res_y;
        n_res_dir    = r_res_dir;
        n_res_carved = r_res_carved;
        n_res_fin    = r_res_fin;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode  = s_axis_tuser;
                    n_rnd   = s_axis_tdata[RND_W-1:0];
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_res_x      = '0;
                n_res_y      = '0;
                n_res_dir    = DIR_NORTH;
                n_res_carved = 1'b0;
                n_res_fin    = 1'b0;
                if (r_mode == MODE_RESTART) begin
                    n_emit  = 1'b1;
                    n_clr   = '0;
                    n_state = S_CLR;
                end else if (r_remain == '0) begin
                    n_res_fin = 1'b1;   // maze already complete
                    n_state   = S_EMIT;
                end else if (r_depth == '0) begin
                    n_state = S_EMIT;   // empty stack: nothing to do
                end else begin
                    n_phase = '0;
                    n_state = S_RD;
                end
            end
            S_CLR: begin
                if (r_clr == '1) begin
                    n_depth  = DW'(1);
                    n_remain = SAW'(CELLS - 1);
                    n_top_x  = '0;
                    n_top_y  = '0;
                    if (r_emit) begin
                        n_emit       = 1'b0;
                        n_res_x      = '0;
                        n_res_y      = '0;
                        n_res_dir    = DIR_NORTH;
                        n_res_carved = 1'b0;
                        n_res_fin    = 1'b0;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_clr = r_clr + VAW'(1);
                end
            end
            S_RD: begin
                // read issued at phase k returns at phase k+1
                if (r_phase == 3'd0) begin
                    n_mod3 = mod3(r_rnd);
                end else begin
                    n_vis[r_phase[1:0] - 2'd1] = w_vis_rdata;
                end
                if (r_phase == 3'd4) begin
                    n_state = S_DEC;
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            S_DEC: begin
                n_res_x = COORD_W'(r_top_x);
                n_res_y = COORD_W'(r_top_y);
                if (w_pick.valid) begin
                    n_res_dir    = w_pick.dir;
                    n_res_carved = 1'b1;
                    n_res_fin    = (r_remain == SAW'(1));
                    n_remain     = r_remain - SAW'(1);
                    if (r_depth < DW'(CELLS)) begin
                        n_depth = r_depth + DW'(1);
                        n_top_x = w_next[VAW-1:YW];
                        n_top_y = w_next[YW-1:0];
                    end
                end else begin
                    // backtrack: the entry below becomes the top
                    n_res_dir    = DIR_NORTH;
                    n_res_carved = 1'b0;
                    n_res_fin    = 1'b0;
                    n_depth      = r_depth - DW'(1);
                    n_top_x      = w_stk_rdata[VAW-1:YW];
                    n_top_y      = w_stk_rdata[YW-1:0];
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'd0, r_res_dir, r_res_y, r_res_x};
                    n_out_user  = {r_res_fin, r_res_carved};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;   // sweep the visited map after reset
            r_phase     <= '0;
            r_clr       <= '0;
            r_emit      <= 1'b0;
            r_depth     <= DW'(1);
            r_remain    <= SAW'(CELLS - 1);
            r_top_x     <= '0;
            r_top_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_clr       <= n_clr;
            r_emit      <= n_emit;
            r_depth     <= n_depth;
            r_remain    <= n_remain;
            r_top_x     <= n_top_x;
            r_top_y     <= n_top_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_rnd        <= n_rnd;
        r_mod3       <= n_mod3;
        r_vis        <= n_vis;
        r_res_x      <= n_res_x;
        r_res_y      <= n_res_y;
        r_res_dir    <= n_res_dir;
        r_res_carved <= n_res_carved;
        r_res_fin    <= n_res_fin;
        r_out_data   <= n_out_data;
        r_out_user   <= n_out_user;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // decision cycle outcomes watched below
    assign w_dec_carve = (r_state == S_DEC) && w_pick.valid;
    assign w_dec_pop   = (r_state == S_DEC) && !w_pick.valid;

    // the path never runs empty: the maze completes before the last pop
    `GMB_ASSERT_NOW(a_depth_nonzero, i_clk, i_rst_n, 1'b1, r_depth != '0)
    // every carve uses up exactly one unvisited cell
    `GMB_ASSERT_NEXT(a_carve_count, i_clk, i_rst_n, w_dec_carve, r_remain == $past(r_remain) - 1'b1)
    // a backtrack drops exactly one stack entry
    `GMB_ASSERT_NEXT(a_pop_depth, i_clk, i_rst_n, w_dec_pop, r_depth == $past(r_depth) - 1'b1)

endmodule

@@ tb/sv/tb.sv @@
// testbench for grid_maze_backtracker: drives restart and carve words into s_axis,
// mirrors the depth-first carve in a scoreboard class and checks every m_axis word
// depends on gmb_pkg and the grid_maze_backtracker rtl
module tb
    import gmb_pkg::*;
();

    // grid geometry, same as the block's defaults
    localparam int GW     = GRID_WIDTH_DEF;
    localparam int GH     = GRID_HEIGHT_DEF;
    localparam int CELLS  = GW * GH;
    localparam int CELL_W = $clog2(CELLS);

    // bit positions inside the output tdata
    localparam int Y_LSB   = COORD_W;
    localparam int DIR_LSB = 2 * COORD_W;

    localparam int     CLK_HALF       = 2;
    localparam int     RESET_CYCLES   = 7;
    localparam int     HOLD_CYCLES    = 400;    // long receiver stall
    localparam int     TAIL_CYCLES    = 24;     // idle tail after the last word
    localparam longint TIMEOUT_CYCLES = 600000;

    // one expected output word, split into its fields
    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [DIR_W-1:0]   direction;
        logic               carved;
        logic               finished;
    } t_carve_word;

    // mirror of the carving state plus the queue of words still owed by the block
    class t_carve_scoreboard;
        bit                visited [CELLS];
        logic [CELL_W-1:0] path    [CELLS];
        logic [CELL_W:0]   depth;
        logic [CELL_W-1:0] remaining;
        t_carve_word       pending_words [$];
        int                mismatch_count = 0;
        int                n_checked      = 0;
        int                n_carve        = 0;
        int                n_backtrack    = 0;
        int                n_restart      = 0;
        int                n_done_steps   = 0;

        function new();
            restart_grid();
        endfunction

        function void restart_grid();
            foreach (visited[i]) visited[i] = 1'b0;
            foreach (path[i]) path[i] = '0;
            visited[0] = 1'b1;
            path[0]    = '0;
            depth      = 1;
            remaining  = CELL_W'(CELLS - 1);
        endfunction

        // one carve step or restart, updates the mirror and returns the word it causes
        function t_carve_word carve_step(logic mode, logic [RND_W-1:0] rnd);
            t_carve_word      w;
            int               top, x, y, count, pick;
            logic [DIR_W-1:0] dirs [4];
            int               cand [4];
            w = '0;
            if (mode == MODE_RESTART) begin
                restart_grid();
                n_restart++;
                return w;
            end
            if (remaining == 0) begin
                // maze complete, step does nothing
                w.finished = 1'b1;
                n_done_steps++;
                return w;
            end
            if (depth == 0 || depth > CELLS) begin
                return w;
            end
            top   = int'(path[depth - 1]);
            x     = top / GH;
            y     = top % GH;
            count = 0;
            // neighbours tested north, south, east, west
            if (y > 0 && !visited[top - 1]) begin
                dirs[count] = DIR_NORTH; cand[count] = top - 1; count++;
            end
            if (y < GH - 1 && !visited[top + 1]) begin
                dirs[count] = DIR_SOUTH; cand[count] = top + 1; count++;
            end
            if (x < GW - 1 && !visited[top + GH]) begin
                dirs[count] = DIR_EAST; cand[count] = top + GH; count++;
            end
            if (x > 0 && !visited[top - GH]) begin
                dirs[count] = DIR_WEST; cand[count] = top - GH; count++;
            end
            w.cell_x = COORD_W'(x);
            w.cell_y = COORD_W'(y);
            if (count > 0) begin
                pick = int'(rnd) % count;
                if (depth < CELLS) begin
                    path[depth] = CELL_W'(cand[pick]);
                    depth++;
                end
                visited[cand[pick]] = 1'b1;
                remaining--;
                w.direction = dirs[pick];
                w.carved    = 1'b1;
                w.finished  = (remaining == 0);
                n_carve++;
            end else begin
                // dead end, pop the top cell
                depth--;
                n_backtrack++;
            end
            return w;
        endfunction

        function void note_item(logic mode, logic [RND_W-1:0] rnd);
            pending_words.insert(pending_words.size(), carve_step(mode, rnd));
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatch_count++;
        endtask

        task check_word(logic [15:0] tdata, logic [1:0] tuser);
            t_carve_word want;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("word with none expected, tdata %h tuser %b",
                                          tdata, tuser));
                return;
            end
            want = pending_words.pop_front();
            n_checked++;
            if (tdata[COORD_W-1:0] !== want.cell_x ||
                tdata[Y_LSB +: COORD_W] !== want.cell_y ||
                tdata[DIR_LSB +: DIR_W] !== want.direction ||
                tuser[0] !== want.carved ||
                tuser[1] !== want.finished) begin
                report_mismatch($sformatf(
                    "word %0d got x %0d y %0d dir %0d carved %b fin %b, want %0d %0d %0d %b %b",
                    n_checked, tdata[COORD_W-1:0], tdata[Y_LSB +: COORD_W],
                    tdata[DIR_LSB +: DIR_W], tuser[0], tuser[1], want.cell_x,
                    want.cell_y, want.direction, want.carved, want.finished));
            end
        endtask
    endclass

    // clock, reset and block ports; the block's inputs are known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [14:0] random_value, [15] zero fill
    logic        s_axis_tuser  = 1'b1; // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [4:0] cell_x, [9:5] cell_y, [11:10] direction
    logic [1:0]  m_axis_tuser;         // [0] carved, [1] finished

    // idle limits per side, changed between phases and during the full maze
    int   tx_max   = 15;
    int   rx_max   = 15;
    // long receiver stall request and its active flag
    logic hold_req = 1'b0;
    logic rx_hold  = 1'b0;

    t_carve_scoreboard carve_sb = new();

    grid_maze_backtracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 unit period, rising edges at 2, 6, 10 ...
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // offer one word after a random gap; entered and left at a falling edge
    task send_item(input logic mode, input logic [RND_W-1:0] rnd);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, rnd};
        // word moves on the first rising edge with tready high
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        carve_sb.note_item(mode, rnd);
        @(negedge i_clk);
    endtask

    // sender pause until every expected word has come back
    task wait_results_done();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (carve_sb.pending() != 0);
    endtask

    // receiver: random tready gaps, sampled and checked at the rising edge
    initial begin
        int rx_wait;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                carve_sb.check_word(m_axis_tdata, m_axis_tuser);
                rx_wait = $urandom_range(0, rx_max);
            end
            @(negedge i_clk);
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // long stall, counted in its own process; flag moves only on rising edges
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // stimulus
    initial begin
        int run, run_len, steps;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: random word extremes and bit patterns, restarts back to back
        // (tready stays low through the clearing sweep after reset)
        send_item(MODE_STEP, 15'h0000);
        send_item(MODE_STEP, 15'h7fff);
        send_item(MODE_STEP, 15'h5555);
        send_item(MODE_STEP, 15'h2aaa);
        send_item(MODE_STEP, 15'h0001);
        send_item(MODE_RESTART, 15'h7fff);
        send_item(MODE_STEP, 15'h7fff);
        send_item(MODE_RESTART, 15'h0000);
        send_item(MODE_RESTART, 15'h5555);
        send_item(MODE_STEP, 15'h0002);
        send_item(MODE_STEP, 15'h0003);
        send_item(MODE_STEP, 15'h4000);
        send_item(MODE_STEP, 15'h7ffe);
        send_item(MODE_STEP, 15'h2aaa);
        wait_results_done();

        // short carves from a restart, one per idle mix, with the odd restart inside
        for (run = 0; run < 4; run++) begin
            tx_max = (run % 2 != 0) ? 15 : 0;
            rx_max = ((run / 2) % 2 != 0) ? 15 : 0;
            send_item(MODE_RESTART, RND_W'($urandom));
            run_len = $urandom_range(10, 40);
            for (steps = 0; steps < run_len; steps++) begin
                if ($urandom_range(0, 39) == 0) begin
                    send_item(MODE_RESTART, RND_W'($urandom));
                end else begin
                    send_item(MODE_STEP, RND_W'($urandom));
                end
            end
            wait_results_done();
        end

        // one full maze: carve until every cell is visited
        tx_max = 15;
        rx_max = 15;
        send_item(MODE_RESTART, RND_W'($urandom));
        steps = 0;
        while (carve_sb.remaining != 0) begin
            if (steps % 256 == 0) begin
                tx_max = ($urandom_range(0, 1) != 0) ? 15 : 0;
                rx_max = ($urandom_range(0, 1) != 0) ? 15 : 0;
            end
            if (steps == 300) begin
                // back-to-back words against a stalled receiver
                tx_max   = 0;
                hold_req = 1'b1;
            end
            send_item(MODE_STEP, RND_W'($urandom));
            steps++;
        end
        // steps on the finished maze, then a fresh start
        repeat (8) send_item(MODE_STEP, RND_W'($urandom));
        send_item(MODE_RESTART, RND_W'($urandom));
        repeat (6) send_item(MODE_STEP, RND_W'($urandom));

        wait_results_done();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("checked %0d words: %0d carves, %0d backtracks, %0d restarts",
                 carve_sb.n_checked, carve_sb.n_carve, carve_sb.n_backtrack,
                 carve_sb.n_restart);
        $display("%0d steps on a finished maze, one full maze, one long output stall",
                 carve_sb.n_done_steps);
        if (carve_sb.mismatch_count == 0 && carve_sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("simulation failed");
        $finish;
    end

endmodule
